### hdl/msv_pkg.sv
// Package for the MessagePack stream validator.
// Holds parse phases, token kinds, status codes and default limits.
// No dependencies.
package msv_pkg;

    localparam int MaxNestDefault   = 64;
    localparam int MaxValuesDefault = 4096;

    localparam logic [2:0] StBusy      = 3'd0;
    localparam logic [2:0] StComplete  = 3'd1;
    localparam logic [2:0] StTruncated = 3'd2;
    localparam logic [2:0] StTrailing  = 3'd3;
    localparam logic [2:0] StReserved  = 3'd4;
    localparam logic [2:0] StDepth     = 3'd5;
    localparam logic [2:0] StValues    = 3'd6;

    localparam logic [3:0] KNone  = 4'd0;
    localparam logic [3:0] KUint  = 4'd1;
    localparam logic [3:0] KSint  = 4'd2;
    localparam logic [3:0] KNil   = 4'd3;
    localparam logic [3:0] KFalse = 4'd4;
    localparam logic [3:0] KTrue  = 4'd5;
    localparam logic [3:0] KF32   = 4'd6;
    localparam logic [3:0] KF64   = 4'd7;
    localparam logic [3:0] KStr   = 4'd8;
    localparam logic [3:0] KBin   = 4'd9;
    localparam logic [3:0] KArray = 4'd10;
    localparam logic [3:0] KMap   = 4'd11;
    localparam logic [3:0] KExt   = 4'd12;

    localparam logic CfgDepth  = 1'b0;
    localparam logic CfgValues = 1'b1;

    typedef enum logic [2:0] {
        t_ph_marker,
        t_ph_field,
        t_ph_exttype,
        t_ph_payload,
        t_ph_done
    } t_phase;

    typedef enum logic [2:0] {
        t_fsm_idle,
        t_fsm_pop_rd,
        t_fsm_pop_chk,
        t_fsm_out
    } t_fsm;

endpackage

### hdl/messagepack_stream_validator_unit.sv
// Top level of the MessagePack stream validator.
// Parses one byte per item; container counts live in a synchronous stack memory.
// Depends on msv_pkg.
//
//  channel | direction | signals
//  in      | sink      | i_valid, o_ready, i_data_byte, i_final_byte
//  out     | source    | o_valid, i_ready, o_status .. o_error_offset
//  cfg     | sink      | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data
//
// An item passes through accept and result load when no container count is read
// back; every value that ends inside a container adds a read and a check for each
// stack level it reads back, the synchronous read of the count stack setting the pace.
// Reset is synchronous; the stack needs no clearing pass.
// A result waits in the output register while the next item is parsed; the
// result load stalls only while that register is still full.
module messagepack_stream_validator_unit #(
    parameter int MAX_NEST   = msv_pkg::MaxNestDefault,
    parameter int MAX_VALUES = msv_pkg::MaxValuesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_token_kind,
    output logic [63:0] o_token_value,
    output logic [7:0]  o_ext_type_code,
    output logic [6:0]  o_nest_level,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [31:0] o_error_offset,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import msv_pkg::*;

    localparam int StackSize = MAX_NEST + 1;
    localparam int AW = $clog2(StackSize + 1);
    localparam int VW = $clog2(MAX_VALUES + 2);

    logic [32:0] r_mem [StackSize];
    logic [32:0] r_rd;

    t_fsm   r_fsm, n_fsm;
    t_phase r_phase, n_phase;
    logic [AW-1:0] r_top, n_top;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_fleft, n_fleft, r_fsize, n_fsize;
    logic [31:0] r_pleft, n_pleft;
    logic [3:0]  r_pkind, n_pkind;
    logic [VW-1:0] r_vseen, n_vseen;
    logic [31:0] r_pos, n_pos, r_fstart, n_fstart;
    logic [2:0]  r_err, n_err;
    logic [7:0]  r_ext, n_ext;
    logic [6:0]  r_dlim;
    logic [12:0] r_vlim;
    logic        r_fin, n_fin;

    logic        r_ovalid;
    logic [2:0]  r_status, n_status;
    logic [3:0]  r_tkind, n_tkind;
    logic [63:0] r_tval, n_tval;
    logic [7:0]  r_text, n_text;
    logic [6:0]  r_tlvl, n_tlvl;
    logic        r_pv, n_pv;
    logic [7:0]  r_pb, n_pb;
    logic [31:0] r_eoff, n_eoff;

    logic [3:0]  r_okind;
    logic [63:0] r_oval;
    logic [7:0]  r_oext;
    logic [6:0]  r_olvl;
    logic        r_opv;
    logic [7:0]  r_opb;
    logic        out_load;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [32:0]   wr_data;
    logic          pop_start;

    logic [AW-1:0] eff_depth;
    logic [VW-1:0] eff_vals;
    logic          accept;

    assign eff_depth = ({25'd0, r_dlim} > 32'(MAX_NEST)) ? AW'(MAX_NEST) : AW'(r_dlim);
    assign eff_vals  = ({19'd0, r_vlim} > 32'(MAX_VALUES)) ? VW'(MAX_VALUES) : VW'(r_vlim);

    assign o_ready     = (r_fsm == t_fsm_idle);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign out_load    = (r_fsm == t_fsm_out) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[$clog2(StackSize)-1:0]] <= wr_data;
        end
        r_rd <= r_mem[rd_addr[$clog2(StackSize)-1:0]];
    end

    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            t_fsm_idle:    if (accept) n_fsm = pop_start ? t_fsm_pop_rd : t_fsm_out;
            t_fsm_pop_rd:  n_fsm = t_fsm_pop_chk;
            t_fsm_pop_chk: n_fsm = pop_start ? t_fsm_pop_rd : t_fsm_out;
            t_fsm_out:     if (out_load) n_fsm = t_fsm_idle;
            default:       n_fsm = t_fsm_idle;
        endcase
    end

    // byte processing, stack pop and result status, one step per state
    always_comb begin
        logic [31:0] nxt;
        logic [7:0]  b;
        logic [63:0] v;
        logic [5:0]  sh;
        logic        done;
        logic        opn;
        logic [32:0] cnt;
        n_phase = r_phase; n_top = r_top; n_acc = r_acc; n_fleft = r_fleft;
        n_fsize = r_fsize; n_pleft = r_pleft; n_pkind = r_pkind; n_vseen = r_vseen;
        n_pos = r_pos; n_fstart = r_fstart; n_err = r_err; n_ext = r_ext; n_fin = r_fin;
        n_status = r_status; n_tkind = r_tkind; n_tval = r_tval; n_text = r_text;
        n_tlvl = r_tlvl; n_pv = r_pv; n_pb = r_pb; n_eoff = r_eoff;
        wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = '0;
        pop_start = 1'b0;
        b = i_data_byte; nxt = r_pos + 32'd1; v = '0; sh = '0;
        done = 1'b0; opn = 1'b0; cnt = '0;

        if (r_fsm == t_fsm_idle && accept) begin
            n_fin = i_final_byte;
            n_pos = nxt;
            n_tkind = KNone; n_tval = '0; n_text = '0; n_tlvl = '0;
            n_pv = 1'b0; n_pb = '0;
            if (r_err == StBusy) begin
                case (r_phase)
                    t_ph_marker: begin
                        n_fstart = r_pos;
                        if (r_top > eff_depth) begin
                            n_err = StDepth;
                        end else if (r_vseen + VW'(1) > eff_vals) begin
                            n_err = StValues;
                        end else begin
                            n_vseen = r_vseen + VW'(1);
                            n_tlvl = 7'(r_top);
                            if (b <= 8'h7F) begin
                                n_tkind = KUint; n_tval = 64'(b); done = 1'b1;
                            end else if (b >= 8'hE0) begin
                                n_tkind = KSint; n_tval = {56'hFF_FFFF_FFFF_FFFF, b};
                                done = 1'b1;
                            end else if (b[7:4] == 4'h8 || b[7:4] == 4'h9) begin
                                n_tkind = (b[4]) ? KArray : KMap;
                                n_tval = 64'(b[3:0]);
                                opn = 1'b1;
                                cnt = b[4] ? 33'(b[3:0]) : 33'({b[3:0], 1'b0});
                            end else if ((b & 8'hE0) == 8'hA0) begin
                                n_tkind = KStr; n_tval = 64'(b & 8'h1F);
                                if ((b & 8'h1F) == 8'd0) begin
                                    done = 1'b1;
                                end else begin
                                    n_pleft = 32'(b & 8'h1F); n_fstart = nxt;
                                    n_phase = t_ph_payload;
                                end
                            end else begin
                                n_fstart = nxt;
                                n_acc = '0;
                                n_phase = t_ph_field;
                                case (b)
                                    8'hC0: begin n_tkind = KNil; done = 1'b1; end
                                    8'hC1: begin n_err = StReserved; n_fstart = r_pos;
                                        n_phase = r_phase; n_tlvl = '0; end
                                    8'hC2: begin n_tkind = KFalse; done = 1'b1; end
                                    8'hC3: begin n_tkind = KTrue; done = 1'b1; end
                                    8'hC4: begin n_pkind = KBin; n_fsize = 4'd1; end
                                    8'hC5: begin n_pkind = KBin; n_fsize = 4'd2; end
                                    8'hC6: begin n_pkind = KBin; n_fsize = 4'd4; end
                                    8'hC7: begin n_pkind = KExt; n_fsize = 4'd1; end
                                    8'hC8: begin n_pkind = KExt; n_fsize = 4'd2; end
                                    8'hC9: begin n_pkind = KExt; n_fsize = 4'd4; end
                                    8'hCA: begin n_pkind = KF32; n_fsize = 4'd4; end
                                    8'hCB: begin n_pkind = KF64; n_fsize = 4'd8; end
                                    8'hCC: begin n_pkind = KUint; n_fsize = 4'd1; end
                                    8'hCD: begin n_pkind = KUint; n_fsize = 4'd2; end
                                    8'hCE: begin n_pkind = KUint; n_fsize = 4'd4; end
                                    8'hCF: begin n_pkind = KUint; n_fsize = 4'd8; end
                                    8'hD0: begin n_pkind = KSint; n_fsize = 4'd1; end
                                    8'hD1: begin n_pkind = KSint; n_fsize = 4'd2; end
                                    8'hD2: begin n_pkind = KSint; n_fsize = 4'd4; end
                                    8'hD3: begin n_pkind = KSint; n_fsize = 4'd8; end
                                    8'hD4, 8'hD5, 8'hD6, 8'hD7, 8'hD8: begin
                                        n_pleft = 32'd1 << (b - 8'hD4);
                                        n_phase = t_ph_exttype;
                                    end
                                    8'hD9: begin n_pkind = KStr; n_fsize = 4'd1; end
                                    8'hDA: begin n_pkind = KStr; n_fsize = 4'd2; end
                                    8'hDB: begin n_pkind = KStr; n_fsize = 4'd4; end
                                    8'hDC: begin n_pkind = KArray; n_fsize = 4'd2; end
                                    8'hDD: begin n_pkind = KArray; n_fsize = 4'd4; end
                                    8'hDE: begin n_pkind = KMap; n_fsize = 4'd2; end
                                    default: begin n_pkind = KMap; n_fsize = 4'd4; end
                                endcase
                                n_fleft = n_fsize;
                            end
                        end
                    end
                    t_ph_field: begin
                        v = {r_acc[55:0], b};
                        n_acc = v;
                        if (r_fleft <= 4'd1) begin
                            n_fleft = '0;
                            n_tlvl = 7'(r_top);
                            case (r_pkind)
                                KSint: begin
                                    n_tkind = KSint;
                                    sh = 6'({r_fsize, 3'b000} - 7'd1);
                                    n_tval = v;
                                    if (r_fsize < 4'd8 && v[sh])
                                        n_tval = v | (~64'd0 << {r_fsize, 3'b000});
                                    done = 1'b1;
                                end
                                KStr, KBin: begin
                                    n_tkind = r_pkind; n_tval = v;
                                    if (v[31:0] == 32'd0) begin
                                        done = 1'b1;
                                    end else begin
                                        n_pleft = v[31:0]; n_fstart = nxt;
                                        n_phase = t_ph_payload;
                                    end
                                end
                                KExt: begin
                                    n_pleft = v[31:0]; n_fstart = nxt;
                                    n_phase = t_ph_exttype; n_tlvl = '0;
                                end
                                KArray, KMap: begin
                                    n_tkind = r_pkind; n_tval = v; opn = 1'b1;
                                    cnt = (r_pkind == KMap) ? {v[31:0], 1'b0} : {1'b0, v[31:0]};
                                end
                                default: begin
                                    n_tkind = r_pkind; n_tval = v; done = 1'b1;
                                end
                            endcase
                        end else begin
                            n_fleft = r_fleft - 4'd1;
                        end
                    end
                    t_ph_exttype: begin
                        n_ext = b;
                        n_tkind = KExt; n_tval = 64'(r_pleft); n_text = b;
                        n_tlvl = 7'(r_top);
                        if (r_pleft == 32'd0) begin
                            done = 1'b1;
                        end else begin
                            n_fstart = nxt; n_phase = t_ph_payload;
                        end
                    end
                    t_ph_payload: begin
                        n_pv = 1'b1; n_pb = b;
                        n_pleft = (r_pleft > 32'd0) ? r_pleft - 32'd1 : r_pleft;
                        if (r_pleft <= 32'd1) done = 1'b1;
                    end
                    default: begin
                        n_fstart = r_pos; n_err = StTrailing;
                    end
                endcase
                if (n_tkind == KNone) n_tlvl = '0;
                if (opn) begin
                    if (n_tval == 64'd0) begin
                        done = 1'b1;
                    end else begin
                        if (r_top < AW'(StackSize)) begin
                            wr_en = 1'b1; wr_addr = r_top; wr_data = cnt;
                            n_top = r_top + AW'(1);
                        end
                        n_fstart = nxt; n_phase = t_ph_marker;
                    end
                end
                if (done) begin
                    if (r_top == '0) begin
                        n_phase = t_ph_done;
                    end else begin
                        pop_start = 1'b1;
                        n_phase = t_ph_marker;
                    end
                end
            end
        end else if (r_fsm == t_fsm_pop_chk) begin
            cnt = (r_rd != 33'd0) ? r_rd - 33'd1 : r_rd;
            wr_en = 1'b1; wr_addr = r_top - AW'(1); wr_data = cnt;
            if (cnt != 33'd0) begin
                n_phase = t_ph_marker;
            end else begin
                n_top = r_top - AW'(1);
                if (n_top == '0) n_phase = t_ph_done;
                else pop_start = 1'b1;
            end
        end
        if (r_fsm == t_fsm_pop_rd) rd_addr = r_top - AW'(1);

        if (out_load) begin
            n_status = StBusy; n_eoff = '0;
            if (r_err != StBusy) begin
                n_status = r_err; n_eoff = r_fstart;
            end else if (r_fin) begin
                if (r_phase == t_ph_done) begin
                    n_status = StComplete;
                end else if (r_phase == t_ph_marker) begin
                    n_eoff = r_pos;
                    if (r_top > eff_depth) n_status = StDepth;
                    else if (r_vseen + VW'(1) > eff_vals) n_status = StValues;
                    else n_status = StTruncated;
                end else begin
                    n_status = StTruncated; n_eoff = r_fstart;
                end
            end
            if (r_fin) begin
                n_phase = t_ph_marker; n_top = '0; n_acc = '0; n_fleft = '0;
                n_fsize = '0; n_pleft = '0; n_pkind = '0; n_vseen = '0; n_pos = '0;
                n_fstart = '0; n_err = StBusy; n_ext = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= t_fsm_idle; r_phase <= t_ph_marker; r_top <= '0;
            r_acc <= '0; r_fleft <= '0; r_fsize <= '0; r_pleft <= '0; r_pkind <= '0;
            r_vseen <= '0; r_pos <= '0; r_fstart <= '0; r_err <= StBusy; r_ext <= '0;
            r_fin <= 1'b0; r_ovalid <= 1'b0;
            r_dlim <= 7'd64; r_vlim <= 13'd4096;
        end else begin
            r_fsm <= n_fsm; r_phase <= n_phase; r_top <= n_top;
            r_acc <= n_acc; r_fleft <= n_fleft; r_fsize <= n_fsize; r_pleft <= n_pleft;
            r_pkind <= n_pkind; r_vseen <= n_vseen; r_pos <= n_pos;
            r_fstart <= n_fstart; r_err <= n_err; r_ext <= n_ext; r_fin <= n_fin;
            if (out_load) r_ovalid <= 1'b1;
            else if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == CfgDepth) r_dlim <= i_cfg_data[6:0];
                else r_vlim <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status; r_tkind <= n_tkind; r_tval <= n_tval; r_text <= n_text;
        r_tlvl <= n_tlvl; r_pv <= n_pv; r_pb <= n_pb; r_eoff <= n_eoff;
        if (out_load) begin
            r_okind <= r_tkind; r_oval <= r_tval; r_oext <= r_text;
            r_olvl <= r_tlvl; r_opv <= r_pv; r_opb <= r_pb;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_token_kind    = r_okind;
    assign o_token_value   = r_oval;
    assign o_ext_type_code = r_oext;
    assign o_nest_level    = r_olvl;
    assign o_payload_valid = r_opv;
    assign o_payload_byte  = r_opb;
    assign o_error_offset  = r_eoff;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm != t_fsm_idle) |-> !o_ready) else $error("item taken while busy");
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= AW'(StackSize)) else $error("stack overflow");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == t_fsm_out) |=> o_valid) else $error("result lost");
    a_pv_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_payload_valid) |-> (o_token_kind == KNone))
        else $error("payload with token");

endmodule

### bench/msv_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the MessagePack stream validator: watches the byte, result and
// register channels, predicts each result and compares it field by field.
// Depends on msv_pkg.
module msv_checker
    import msv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    input  logic        i_out_valid,
    input  logic        i_ready,
    input  logic [2:0]  i_status,
    input  logic [3:0]  i_token_kind,
    input  logic [63:0] i_token_value,
    input  logic [7:0]  i_ext_type_code,
    input  logic [6:0]  i_nest_level,
    input  logic        i_payload_valid,
    input  logic [7:0]  i_payload_byte,
    input  logic [31:0] i_error_offset,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);

    localparam int StackDepth = MaxNestDefault + 1;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  kind;
        logic [63:0] value;
        logic [7:0]  ext;
        logic [6:0]  level;
        logic        pv;
        logic [7:0]  pbyte;
        logic [31:0] eoff;
    } t_verdict;

    t_verdict awaited_verdicts[$];

    logic [6:0]  depth_lim;
    logic [12:0] count_lim;

    t_phase      ph;
    logic [32:0] owed[0:StackDepth-1];
    int unsigned top;
    logic [63:0] acc;
    int unsigned fleft;
    int unsigned fsize;
    logic [31:0] pleft;
    logic [3:0]  pkind;
    int unsigned vseen;
    logic [31:0] pos;
    logic [31:0] fstart;
    logic [2:0]  err;
    logic [7:0]  extc;

    logic [3:0]  tk_kind;
    logic [63:0] tk_value;
    logic [6:0]  tk_level;
    logic [7:0]  tk_ext;

    function automatic int unsigned eff_depth();
        return (depth_lim > MaxNestDefault) ? MaxNestDefault : depth_lim;
    endfunction

    function automatic int unsigned eff_count();
        return (count_lim > MaxValuesDefault) ? MaxValuesDefault : count_lim;
    endfunction

    function automatic void clear_document();
        ph = t_ph_marker;
        for (int i = 0; i < StackDepth; i++) owed[i] = '0;
        top = 0;
        acc = '0;
        fleft = 0;
        fsize = 0;
        pleft = '0;
        pkind = KNone;
        vseen = 0;
        pos = '0;
        fstart = '0;
        err = StBusy;
        extc = '0;
    endfunction

    function automatic void emit(logic [3:0] kind, logic [63:0] val);
        tk_kind = kind;
        tk_value = val;
        tk_level = top[6:0];
        tk_ext = (kind == KExt) ? extc : 8'd0;
    endfunction

    function automatic void close_value();
        while (1) begin
            if (top == 0) begin
                ph = t_ph_done;
                return;
            end
            if (owed[top-1] != 0) owed[top-1] = owed[top-1] - 33'd1;
            if (owed[top-1] != 0) begin
                ph = t_ph_marker;
                return;
            end
            top--;
        end
    endfunction

    function automatic void start_body(logic [31:0] len, logic [31:0] nxt);
        if (len == 0) begin
            close_value();
            return;
        end
        pleft = len;
        fstart = nxt;
        ph = t_ph_payload;
    endfunction

    function automatic void open_nest(logic [3:0] kind, logic [63:0] n, logic [31:0] nxt);
        logic [63:0] owe;
        emit(kind, n);
        if (n == 0) begin
            close_value();
            return;
        end
        owe = (kind == KMap) ? n * 2 : n;
        if (top < StackDepth) begin
            owed[top] = owe[32:0];
            top++;
        end
        fstart = nxt;
        ph = t_ph_marker;
    endfunction

    function automatic void begin_number(logic [3:0] kind, int unsigned size, logic [31:0] nxt);
        pkind = kind;
        fsize = size;
        fleft = size;
        acc = '0;
        fstart = nxt;
        ph = t_ph_field;
    endfunction

    function automatic void finish_field(logic [31:0] nxt);
        logic [63:0] v;
        v = acc;
        case (pkind)
            KSint: begin
                if (fsize < 8 && fsize > 0 && v[8*fsize-1]) v = v | (~64'd0 << (8 * fsize));
                emit(KSint, v);
                close_value();
            end
            KStr, KBin: begin
                emit(pkind, v);
                start_body(v[31:0], nxt);
            end
            KExt: begin
                pleft = v[31:0];
                fstart = nxt;
                ph = t_ph_exttype;
            end
            KArray, KMap: open_nest(pkind, v, nxt);
            default: begin
                emit(pkind, v);
                close_value();
            end
        endcase
    endfunction

    function automatic void take_marker(logic [7:0] m, logic [31:0] p);
        logic [31:0] nxt;
        nxt = p + 1;
        fstart = p;
        if (top > eff_depth()) begin
            err = StDepth;
            return;
        end
        if (vseen + 1 > eff_count()) begin
            err = StValues;
            return;
        end
        vseen++;
        if (m <= 8'h7F) begin
            emit(KUint, {56'd0, m});
            close_value();
        end else if (m >= 8'hE0) begin
            emit(KSint, {{56{1'b1}}, m});
            close_value();
        end else if (m[7:4] == 4'h8) begin
            open_nest(KMap, {60'd0, m[3:0]}, nxt);
        end else if (m[7:4] == 4'h9) begin
            open_nest(KArray, {60'd0, m[3:0]}, nxt);
        end else if (m[7:5] == 3'b101) begin
            emit(KStr, {59'd0, m[4:0]});
            start_body({27'd0, m[4:0]}, nxt);
        end else begin
            case (m)
                8'hC0: begin emit(KNil, 0); close_value(); end
                8'hC1: err = StReserved;
                8'hC2: begin emit(KFalse, 0); close_value(); end
                8'hC3: begin emit(KTrue, 0); close_value(); end
                8'hC4: begin_number(KBin, 1, nxt);
                8'hC5: begin_number(KBin, 2, nxt);
                8'hC6: begin_number(KBin, 4, nxt);
                8'hC7: begin_number(KExt, 1, nxt);
                8'hC8: begin_number(KExt, 2, nxt);
                8'hC9: begin_number(KExt, 4, nxt);
                8'hCA: begin_number(KF32, 4, nxt);
                8'hCB: begin_number(KF64, 8, nxt);
                8'hCC: begin_number(KUint, 1, nxt);
                8'hCD: begin_number(KUint, 2, nxt);
                8'hCE: begin_number(KUint, 4, nxt);
                8'hCF: begin_number(KUint, 8, nxt);
                8'hD0: begin_number(KSint, 1, nxt);
                8'hD1: begin_number(KSint, 2, nxt);
                8'hD2: begin_number(KSint, 4, nxt);
                8'hD3: begin_number(KSint, 8, nxt);
                8'hD4, 8'hD5, 8'hD6, 8'hD7, 8'hD8: begin
                    pleft = 32'd1 << (m - 8'hD4);
                    fstart = nxt;
                    ph = t_ph_exttype;
                end
                8'hD9: begin_number(KStr, 1, nxt);
                8'hDA: begin_number(KStr, 2, nxt);
                8'hDB: begin_number(KStr, 4, nxt);
                8'hDC: begin_number(KArray, 2, nxt);
                8'hDD: begin_number(KArray, 4, nxt);
                8'hDE: begin_number(KMap, 2, nxt);
                default: begin_number(KMap, 4, nxt);
            endcase
        end
    endfunction

    function automatic logic consume_byte(logic [7:0] b, logic [31:0] p);
        logic body;
        body = 1'b0;
        case (ph)
            t_ph_marker: take_marker(b, p);
            t_ph_field: begin
                acc = (acc << 8) | {56'd0, b};
                if (fleft > 0) fleft--;
                if (fleft == 0) finish_field(p + 1);
            end
            t_ph_exttype: begin
                extc = b;
                emit(KExt, {32'd0, pleft});
                start_body(pleft, p + 1);
            end
            t_ph_payload: begin
                body = 1'b1;
                if (pleft > 0) pleft--;
                if (pleft == 0) close_value();
            end
            default: begin
                fstart = p;
                err = StTrailing;
            end
        endcase
        return body;
    endfunction

    function automatic t_verdict predict_result(logic [7:0] b, logic fin);
        t_verdict r;
        logic [31:0] p;
        logic body;
        r = '0;
        p = pos;
        body = 1'b0;
        tk_kind = KNone;
        tk_value = '0;
        tk_level = '0;
        tk_ext = '0;
        pos = p + 1;
        if (err == StBusy) body = consume_byte(b, p);
        if (err != StBusy) begin
            r.status = err;
            r.eoff = fstart;
        end else if (fin) begin
            if (ph == t_ph_done) begin
                r.status = StComplete;
            end else if (ph == t_ph_marker) begin
                r.eoff = pos;
                if (top > eff_depth()) r.status = StDepth;
                else if (vseen + 1 > eff_count()) r.status = StValues;
                else r.status = StTruncated;
            end else begin
                r.status = StTruncated;
                r.eoff = fstart;
            end
        end
        r.kind = tk_kind;
        r.value = tk_value;
        r.ext = tk_ext;
        r.level = tk_level;
        r.pv = body;
        r.pbyte = body ? b : 8'd0;
        if (fin) clear_document();
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        o_fail_count++;
        if (o_fail_count <= 40)
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     o_result_count, what, got, want);
    endtask

    task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want) report(what, got, want);
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_result_count = 0;
        depth_lim = 7'd64;
        count_lim = 13'd4096;
        clear_document();
    end

    always @(posedge i_clk) begin
        t_verdict w;
        if (!i_rst_n) begin
            depth_lim = 7'd64;
            count_lim = 13'd4096;
            clear_document();
            awaited_verdicts.delete();
        end else begin
            if (i_out_valid && i_ready) begin
                o_result_count++;
                if (awaited_verdicts.size() == 0) begin
                    report("unexpected result", {61'd0, i_status}, 0);
                end else begin
                    w = awaited_verdicts.pop_front();
                    compare_field("status", i_status, w.status);
                    compare_field("token_kind", i_token_kind, w.kind);
                    compare_field("token_value", i_token_value, w.value);
                    compare_field("ext_type_code", i_ext_type_code, w.ext);
                    compare_field("nest_level", i_nest_level, w.level);
                    compare_field("payload_valid", i_payload_valid, w.pv);
                    compare_field("payload_byte", i_payload_byte, w.pbyte);
                    compare_field("error_offset", i_error_offset, w.eoff);
                end
            end
            if (i_valid && i_in_ready)
                awaited_verdicts.insert(awaited_verdicts.size(),
                                        predict_result(i_data_byte, i_final_byte));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CfgDepth) depth_lim = i_cfg_data[6:0];
                else count_lim = i_cfg_data;
            end
        end
        o_pending = awaited_verdicts.size();
    end

endmodule

### bench/messagepack_stream_validator_unit_test.sv
`timescale 1ns / 1ps
// Top of the MessagePack stream validator bench: clock, reset, document
// stimulus, register phases and the verdict. Depends on msv_pkg, msv_checker and messagepack_stream_validator_unit.
module messagepack_stream_validator_unit_test;
    import msv_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_final_byte;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [3:0]  o_token_kind;
    logic [63:0] o_token_value;
    logic [7:0]  o_ext_type_code;
    logic [6:0]  o_nest_level;
    logic        o_payload_valid;
    logic [7:0]  o_payload_byte;
    logic [31:0] o_error_offset;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [12:0] i_cfg_data;

    int fail_count;
    int pending;
    int result_count;
    int doc_count;
    int byte_count;
    bit bursting;
    logic [7:0] doc_bytes[$];

    messagepack_stream_validator_unit uut (.*);

    msv_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_in_ready(o_ready),
        .i_data_byte(i_data_byte), .i_final_byte(i_final_byte),
        .i_out_valid(o_valid), .i_ready(i_ready),
        .i_status(o_status), .i_token_kind(o_token_kind), .i_token_value(o_token_value),
        .i_ext_type_code(o_ext_type_code), .i_nest_level(o_nest_level),
        .i_payload_valid(o_payload_valid), .i_payload_byte(o_payload_byte),
        .i_error_offset(o_error_offset),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("messagepack_stream_validator_unit_test: FAIL");
        $finish;
    end

    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = bursting ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(negedge i_clk);
            while (!o_valid) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    task automatic add_byte(logic [7:0] b);
        doc_bytes.insert(doc_bytes.size(), b);
    endtask

    task automatic send_byte(logic [7:0] b, logic fin);
        int gap;
        gap = bursting ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_final_byte <= fin;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        byte_count++;
    endtask

    task automatic send_document();
        bursting = ($urandom_range(0, 3) == 0);
        foreach (doc_bytes[i]) send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
        doc_bytes.delete();
        doc_count++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [12:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_len(int unsigned len, int width);
        for (int i = width - 1; i >= 0; i--) add_byte(8'(len >> (8 * i)));
    endtask

    task automatic push_random(int n);
        repeat (n) add_byte(8'($urandom));
    endtask

    task automatic grow_value(int lvl);
        int pick;
        int n;
        int w;
        pick = $urandom_range(0, 17);
        case (pick)
            1: add_byte(8'($urandom_range(224, 255)));
            2: add_byte(8'($urandom_range(0, 2) == 0 ? 8'hC0 : 8'hC2 + $urandom_range(0, 1)));
            3, 4: begin
                n = $urandom_range(0, 3);
                add_byte(8'((pick == 3 ? 8'hCC : 8'hD0) + n));
                push_random(1 << n);
            end
            5: begin add_byte(8'hCA); push_random(4); end
            6: begin add_byte(8'hCB); push_random(8); end
            7: begin
                n = $urandom_range(0, 6);
                add_byte(8'(8'hA0 | n));
                push_random(n);
            end
            8, 9, 10: begin
                n = $urandom_range(0, 6);
                w = $urandom_range(0, 2);
                add_byte(8'((pick == 8 ? 8'hD9 : pick == 9 ? 8'hC4 : 8'hC7) + w));
                push_len(n, 1 << w);
                if (pick == 10) push_random(1);
                push_random(n);
            end
            11: begin
                n = $urandom_range(0, 4);
                add_byte(8'(8'hD4 + n));
                push_random(1 + (1 << n));
            end
            12, 13, 14, 15: begin
                n = (lvl < 4) ? $urandom_range(0, 3) : 0;
                w = $urandom_range(0, 2);
                if (w == 0) add_byte(8'((pick < 14 ? 8'h90 : 8'h80) | n));
                else begin
                    add_byte(8'((pick < 14 ? 8'hDC : 8'hDE) + w - 1));
                    push_len(n, w == 1 ? 2 : 4);
                end
                repeat ((pick < 14 ? 1 : 2) * n) grow_value(lvl + 1);
            end
            default: add_byte(8'($urandom_range(0, 127)));
        endcase
    endtask

    task automatic random_document();
        int mode;
        int cut;
        grow_value(0);
        mode = $urandom_range(0, 9);
        if (mode == 7 && doc_bytes.size() > 1) begin
            cut = $urandom_range(1, doc_bytes.size() - 1);
            while (doc_bytes.size() > cut) void'(doc_bytes.pop_back());
        end else if (mode == 8) begin
            push_random($urandom_range(1, 3));
        end else if (mode == 9) begin
            if ($urandom_range(0, 1)) doc_bytes.insert($urandom_range(0, doc_bytes.size() - 1), 8'hC1);
            else begin
                doc_bytes.delete();
                push_random($urandom_range(1, 8));
            end
        end
        send_document();
    endtask

    task automatic directed_document(logic [7:0] b[]);
        foreach (b[i]) add_byte(b[i]);
        send_document();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_final_byte = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CfgDepth;
        i_cfg_data = '0;
        bursting = 1'b0;
        doc_count = 0;
        byte_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_document('{8'h00});
        directed_document('{8'hFF});
        directed_document('{8'hD0, 8'h80});
        directed_document('{8'hCF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        directed_document('{8'h92, 8'hC0, 8'hC3, 8'h7F});
        directed_document('{8'hC1, 8'h00, 8'h00});
        directed_document('{8'hDD, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        directed_document('{8'hDB, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h41});
        directed_document('{8'h81, 8'hA1, 8'h6B, 8'hC7, 8'h01, 8'h80, 8'h55});

        write_reg(CfgDepth, 13'd0);
        directed_document('{8'h91, 8'h00});
        write_reg(CfgValues, 13'd0);
        directed_document('{8'h00});
        write_reg(CfgValues, 13'd1);
        directed_document('{8'h92, 8'hC2});
        write_reg(CfgDepth, 13'd127);
        write_reg(CfgValues, 13'd8191);
        repeat (66) add_byte(8'h91);
        add_byte(8'h00);
        send_document();
        add_byte(8'hDC);
        push_len(20, 2);
        repeat (20) add_byte(8'h00);
        send_document();

        for (int phase_n = 0; phase_n < 10; phase_n++) begin
            write_reg(CfgDepth, ($urandom_range(0, 1) ? 13'd64 : 13'($urandom_range(0, 127))));
            write_reg(CfgValues, ($urandom_range(0, 1) ? 13'd4096 :
                                  13'($urandom_range(0, 40))));
            while (byte_count < 200 + 180 * (phase_n + 1)) random_document();
        end

        drain();
        $display("covered %0d documents, %0d bytes, %0d results checked",
                 doc_count, byte_count, result_count);
        if (fail_count == 0) $display("messagepack_stream_validator_unit_test: PASS");
        else $display("messagepack_stream_validator_unit_test: FAIL");
        $finish;
    end

endmodule
